[sv/ascii_integer_field_parser_macros.svh]
// assertion macros used by the parser core
`ifndef ASCII_INTEGER_FIELD_PARSER_MACROS_SVH
`define ASCII_INTEGER_FIELD_PARSER_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define AIFP_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AIFP_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/aifp_pkg.sv]
// types, codes and character helpers for the ascii integer field parser
package aifp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } char_t;

  typedef struct packed {
    logic [63:0] value;
    logic        no_digits;
    logic        ended_by_eof;
    logic [7:0]  terminator;
  } field_t;

  typedef struct packed {
    logic [1:0] base_select;
    logic [1:0] result_size;
    logic       signed_result;
  } cfg_t;

  // configuration register indexes
  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_SIZE   = 2'd1;
  localparam logic [1:0] REG_SIGNED = 2'd2;

  // base_select codes
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // result_size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [4:0] NOT_DIGIT = 5'd16;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // hex digit value of c in either case, NOT_DIGIT otherwise
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      digit_of = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit_of = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      digit_of = 5'(c - 8'h37);
    end else begin
      digit_of = NOT_DIGIT;
    end
  endfunction

  function automatic logic digit_fits(input logic [4:0] d, input logic [1:0] base);
    unique case (base)
      BASE_BIN: digit_fits = (d < 5'd2);
      BASE_OCT: digit_fits = (d < 5'd8);
      BASE_DEC: digit_fits = (d < 5'd10);
      default:  digit_fits = (d < 5'd16);
    endcase
  endfunction

endpackage

[sv/aifp_in_stage.sv]
// input register for the character channel
module aifp_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_stall,
  input  aifp_pkg::char_t char_item,
  output logic            item_valid,
  output aifp_pkg::char_t item,
  input  logic            take
);

  logic accept;

  // a held character blocks new ones until the core takes it
  assign char_stall = item_valid && !take;
  assign accept     = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= char_item;
    end
  end

endmodule

[sv/aifp_core.sv]
// field state, digit accumulation and result register
`include "ascii_integer_field_parser_macros.svh"

module aifp_core #(
  parameter int MAX_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  aifp_pkg::cfg_t   cfg,
  input  logic             item_valid,
  input  aifp_pkg::char_t  item,
  output logic             take,
  output logic             field_valid,
  input  logic             field_stall,
  output aifp_pkg::field_t field_item
);

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // stored widths, limited by the accumulator width
  localparam int SW0 = (MAX_WIDTH < 8)  ? MAX_WIDTH : 8;
  localparam int SW1 = (MAX_WIDTH < 16) ? MAX_WIDTH : 16;
  localparam int SW2 = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
  localparam int SW3 = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam logic [63:0] MASK0 = (SW0 >= 64) ? '1 : ((64'd1 << SW0) - 64'd1);
  localparam logic [63:0] MASK1 = (SW1 >= 64) ? '1 : ((64'd1 << SW1) - 64'd1);
  localparam logic [63:0] MASK2 = (SW2 >= 64) ? '1 : ((64'd1 << SW2) - 64'd1);
  localparam logic [63:0] MASK3 = (SW3 >= 64) ? '1 : ((64'd1 << SW3) - 64'd1);
  localparam logic [5:0] SBIT0 = 6'(SW0 - 1);
  localparam logic [5:0] SBIT1 = 6'(SW1 - 1);
  localparam logic [5:0] SBIT2 = 6'(SW2 - 1);
  localparam logic [5:0] SBIT3 = 6'(SW3 - 1);

  logic [1:0]           phase, phase_next;
  logic [MAX_WIDTH-1:0] acc, acc_next;
  logic                 negative, negative_next;
  logic                 seen_digit, seen_digit_next;

  logic [4:0]           digit;
  logic                 digit_ok;
  logic                 blank;
  logic                 is_sign;
  logic                 emit;
  logic [7:0]           term;
  logic [MAX_WIDTH-1:0] digit_ext;
  logic [MAX_WIDTH-1:0] acc_step;
  logic [MAX_WIDTH-1:0] acc_signed;
  logic [63:0]          wide;
  logic [63:0]          mask;
  logic [5:0]           sbit;
  logic [63:0]          value;

  assign digit     = aifp_pkg::digit_of(item.char_code);
  assign digit_ok  = aifp_pkg::digit_fits(digit, cfg.base_select);
  assign blank     = aifp_pkg::is_blank(item.char_code);
  assign is_sign   = (item.char_code == aifp_pkg::CH_PLUS) ||
                     (item.char_code == aifp_pkg::CH_MINUS);
  assign digit_ext = MAX_WIDTH'(digit[3:0]);

  // acc * base + digit, by shifts
  always_comb begin
    unique case (cfg.base_select)
      aifp_pkg::BASE_BIN: acc_step = (acc << 1) + digit_ext;
      aifp_pkg::BASE_OCT: acc_step = (acc << 3) + digit_ext;
      aifp_pkg::BASE_DEC: acc_step = (acc << 3) + (acc << 1) + digit_ext;
      default:            acc_step = (acc << 4) + digit_ext;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    negative_next   = negative;
    seen_digit_next = seen_digit;
    emit            = 1'b0;
    term            = item.char_code;
    if (item.end_of_input) begin
      emit = 1'b1;
      term = 8'd0;
    end else if (phase == PH_SKIP && blank) begin
      phase_next = PH_SKIP;
    end else if (phase == PH_SKIP && is_sign) begin
      negative_next = (item.char_code == aifp_pkg::CH_MINUS);
      phase_next    = PH_SIGN;
    end else if (digit_ok) begin
      acc_next        = acc_step;
      seen_digit_next = 1'b1;
      phase_next      = PH_DIGITS;
    end else begin
      emit = 1'b1;
    end
    // a finished field starts over; the terminator is not examined again
    if (emit) begin
      phase_next      = PH_SKIP;
      acc_next        = '0;
      negative_next   = 1'b0;
      seen_digit_next = 1'b0;
    end
  end

  // negate, truncate to the stored width, then extend
  assign acc_signed = negative ? (~acc + MAX_WIDTH'(1)) : acc;
  assign wide       = 64'(acc_signed);

  always_comb begin
    unique case (cfg.result_size)
      aifp_pkg::SIZE_8: begin
        mask = MASK0;
        sbit = SBIT0;
      end
      aifp_pkg::SIZE_16: begin
        mask = MASK1;
        sbit = SBIT1;
      end
      aifp_pkg::SIZE_32: begin
        mask = MASK2;
        sbit = SBIT2;
      end
      default: begin
        mask = MASK3;
        sbit = SBIT3;
      end
    endcase
    value = wide & mask;
    if (cfg.signed_result && wide[sbit]) begin
      value = value | ~mask;
    end
    if (!seen_digit) begin
      value = 64'd0;
    end
  end

  // an item that ends a field waits only while the result register is full and stalled
  assign take = item_valid && (!emit || !field_valid || !field_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      acc         <= '0;
      negative    <= 1'b0;
      seen_digit  <= 1'b0;
      field_valid <= 1'b0;
    end else begin
      if (take) begin
        phase      <= phase_next;
        acc        <= acc_next;
        negative   <= negative_next;
        seen_digit <= seen_digit_next;
      end
      if (take && emit) begin
        field_valid <= 1'b1;
      end else if (!field_stall) begin
        field_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      field_item.value        <= value;
      field_item.no_digits    <= !seen_digit;
      field_item.ended_by_eof <= item.end_of_input;
      field_item.terminator   <= term;
    end
  end

  `AIFP_NEXT(a_field_restart, take && emit,
    phase == PH_SKIP && !seen_digit && acc == '0, "field state not cleared after result")
  `AIFP_IMPLIES(a_digit_phase, seen_digit, phase == PH_DIGITS,
    "digit seen outside digit phase")
  `AIFP_IMPLIES(a_empty_zero, field_valid && field_item.no_digits,
    field_item.value == 64'd0, "empty field with nonzero value")
  `AIFP_IMPLIES(a_eof_term, field_valid && field_item.ended_by_eof,
    field_item.terminator == 8'd0, "end of input with terminator set")

endmodule

[sv/ascii_integer_field_parser.sv]
// characters pass the input register; the core writes each ended field to the result register
// throughput: one character per cycle; an ending character waits only while a result is stalled
// the accumulator update is a shift-add of the MAX_WIDTH-bit accumulator
// synchronous reset clears the field state and the valid flags of both pipeline registers
// reset sets decimal base, 32-bit result size and sign extension
module ascii_integer_field_parser #(
  parameter int MAX_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  aifp_pkg::char_t  char_item,
  output logic             field_valid,
  input  logic             field_stall,
  output aifp_pkg::field_t field_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [1:0]       cfg_data
);

  aifp_pkg::cfg_t  cfg;
  aifp_pkg::char_t item;
  logic            item_valid;
  logic            take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_select   <= aifp_pkg::BASE_DEC;
      cfg.result_size   <= aifp_pkg::SIZE_32;
      cfg.signed_result <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aifp_pkg::REG_BASE:   cfg.base_select   <= cfg_data;
        aifp_pkg::REG_SIZE:   cfg.result_size   <= cfg_data;
        aifp_pkg::REG_SIGNED: cfg.signed_result <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  aifp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  aifp_core #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_item  (field_item)
  );

endmodule

[tb/tb_ascii_integer_field_parser.sv]
// self-checking testbench for the ascii integer field parser
module tb_ascii_integer_field_parser;

  localparam logic [1:0] REG_SPARE  = 2'd3;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF    = 4;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 105;

  typedef enum logic [1:0] {SCAN_BLANKS, SCAN_SIGNED, SCAN_DIGITS} scan_phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             char_valid = 1'b0;
  logic             char_stall;
  aifp_pkg::char_t  char_item = '0;
  logic             field_valid;
  logic             field_stall = 1'b0;
  aifp_pkg::field_t field_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [1:0]       cfg_data = '0;

  // predicted parser state and register copy
  scan_phase_t scan_phase = SCAN_BLANKS;
  logic [63:0] acc = '0;
  logic        neg_seen = 1'b0;
  logic        digit_seen = 1'b0;
  logic [1:0]  cur_base = aifp_pkg::BASE_DEC;
  logic [1:0]  cur_size = aifp_pkg::SIZE_32;
  logic        cur_signed = 1'b1;

  aifp_pkg::char_t  char_q[$];
  aifp_pkg::field_t fields_due[$];
  int     char_gap = 0;
  int     stall_left = 0;
  bit     calm = 1'b0;
  int     fail_count = 0;
  int     cycle_count = 0;

  always #1 clk = ~clk;

  ascii_integer_field_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_item   (char_item),
    .field_valid (field_valid),
    .field_stall (field_stall),
    .field_item  (field_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  function automatic logic blank_char(input logic [7:0] c);
    return (c == aifp_pkg::CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic [4:0] digit_val(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c inside {[8'h30:8'h39]}) d = c[4:0] - 5'd16;
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) d = {2'b0, c[2:0]} + 5'd9;
    return d;
  endfunction

  function automatic logic [4:0] radix(input logic [1:0] base);
    case (base)
      aifp_pkg::BASE_BIN: return 5'd2;
      aifp_pkg::BASE_OCT: return 5'd8;
      aifp_pkg::BASE_DEC: return 5'd10;
      default:            return 5'd16;
    endcase
  endfunction

  // advance the predicted state by one character; returns 1 when a field ends
  function automatic bit convert_char(input aifp_pkg::char_t c, output aifp_pkg::field_t f);
    logic [4:0]  d;
    logic [63:0] v;
    logic [63:0] m;
    int          sw;
    f = '0;
    if (!c.end_of_input && scan_phase == SCAN_BLANKS) begin
      if (blank_char(c.char_code)) return 1'b0;
      if (c.char_code == aifp_pkg::CH_PLUS || c.char_code == aifp_pkg::CH_MINUS) begin
        neg_seen = (c.char_code == aifp_pkg::CH_MINUS);
        scan_phase = SCAN_SIGNED;
        return 1'b0;
      end
    end
    d = digit_val(c.char_code);
    if (!c.end_of_input && d < radix(cur_base)) begin
      acc = acc * 64'(radix(cur_base)) + 64'(d);
      digit_seen = 1'b1;
      scan_phase = SCAN_DIGITS;
      return 1'b0;
    end
    sw = 8 << cur_size;
    v = neg_seen ? -acc : acc;
    m = (sw >= 64) ? '1 : (64'd1 << sw) - 64'd1;
    v &= m;
    if (cur_signed && sw < 64 && v[sw-1]) v |= ~m;
    f.value = digit_seen ? v : '0;
    f.no_digits = !digit_seen;
    f.ended_by_eof = c.end_of_input;
    f.terminator = c.end_of_input ? 8'h00 : c.char_code;
    scan_phase = SCAN_BLANKS;
    acc = '0;
    neg_seen = 1'b0;
    digit_seen = 1'b0;
    return 1'b1;
  endfunction

  // character driver
  always @(posedge clk) begin
    aifp_pkg::field_t due;
    if (rst) begin
      char_valid <= 1'b0;
      char_gap = 0;
    end else begin
      if (char_valid && !char_stall) begin
        if (convert_char(char_item, due)) fields_due.push_back(due);
        char_gap = calm ? 0 : $urandom_range(0, 13);
      end
      if (!char_valid || !char_stall) begin
        if (char_gap > 0) begin
          char_gap--;
          char_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          char_item <= char_q.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    aifp_pkg::field_t want;
    if (rst) begin
      field_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (field_valid && !field_stall) begin
        if (fields_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected field transfer: %h", field_item);
        end else begin
          want = fields_due.pop_front();
          if (field_item.value !== want.value || field_item.no_digits !== want.no_digits ||
              field_item.ended_by_eof !== want.ended_by_eof ||
              field_item.terminator !== want.terminator) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h %b %b %h, got %h %b %b %h",
                       want.value, want.no_digits, want.ended_by_eof, want.terminator,
                       field_item.value, field_item.no_digits, field_item.ended_by_eof,
                       field_item.terminator);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 13);
      end else if (field_valid && stall_left > 0) begin
        stall_left--;
      end
      field_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      aifp_pkg::REG_BASE:   cur_base = data;
      aifp_pkg::REG_SIZE:   cur_size = data;
      aifp_pkg::REG_SIGNED: cur_signed = data[0];
      default:              ;
    endcase
  endtask

  // wait until every character is sent and every field has come back
  // sampled away from the rising edge so driver updates have settled
  task automatic settle();
    do @(negedge clk); while (char_q.size() > 0 || char_valid || fields_due.size() > 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic push_char(input logic [7:0] c);
    aifp_pkg::char_t it;
    it.char_code = c;
    it.end_of_input = 1'b0;
    char_q.push_back(it);
  endtask

  task automatic push_eof(input logic [7:0] c);
    aifp_pkg::char_t it;
    it.char_code = c;
    it.end_of_input = 1'b1;
    char_q.push_back(it);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 5) == 0) ? aifp_pkg::CH_SPACE :
                                         8'(8'h09 + $urandom_range(0, 4));
  endfunction

  // any byte that is not a digit of the base, biased toward blanks, signs and comma
  function automatic logic [7:0] rand_stop(input logic [1:0] base);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = rand_blank();
      1: c = aifp_pkg::CH_PLUS;
      2: c = aifp_pkg::CH_MINUS;
      3: c = 8'h2C;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (digit_val(c) < radix(base)) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // one field: blanks, optional sign, digits, then a stopping character or end of input; or a lone random character
  task automatic gen_field(input logic [1:0] base, output int n);
    int         r;
    int         len;
    logic [4:0] d;
    n = 0;
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 4) == 0) push_eof(8'($urandom_range(0, 255)));
      else push_char(8'($urandom_range(0, 255)));
      n = 1;
      return;
    end
    r = $urandom_range(0, 2);
    repeat (r) push_char(rand_blank());
    n += r;
    case ($urandom_range(0, 3))
      0: begin push_char(aifp_pkg::CH_MINUS); n++; end
      1: begin push_char(aifp_pkg::CH_PLUS); n++; end
      default: ;
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) len = 0;
    else if (r < 3) len = $urandom_range(12, (base == aifp_pkg::BASE_BIN) ? 70 : 24);
    else len = $urandom_range(1, 6);
    repeat (len) begin
      d = 5'($urandom_range(0, radix(base) - 1));
      if (d < 10) push_char(8'h30 + 8'(d));
      else push_char(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10);
    end
    n += len + 1;
    if ($urandom_range(0, 4) == 0) push_eof(8'($urandom_range(0, 255)));
    else push_char(rand_stop(base));
  endtask

  initial begin
    int count;
    int n;
    logic [1:0] b;
    logic [1:0] s;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: decimal, 32 bits, sign extension; every blank skipped
    for (int c = 9; c <= 13; c++) push_char(8'(c));
    push_char(aifp_pkg::CH_SPACE);
    push_text("-42;");
    push_text("+7+");          // second sign ends the field
    push_text("- ");           // blank after a sign gives no digits
    push_eof(8'hFF);           // end of input while skipping blanks
    settle();

    write_reg(aifp_pkg::REG_BASE, aifp_pkg::BASE_HEX);
    write_reg(aifp_pkg::REG_SIZE, aifp_pkg::SIZE_8);
    write_reg(aifp_pkg::REG_SIGNED, 2'd0);
    push_text("-aB");
    push_eof(8'h00);
    settle();

    write_reg(aifp_pkg::REG_BASE, aifp_pkg::BASE_BIN);
    write_reg(aifp_pkg::REG_SIZE, aifp_pkg::SIZE_64);
    write_reg(aifp_pkg::REG_SIGNED, 2'd3);
    write_reg(REG_SPARE, 2'd0); // index outside the register list
    push_text("-102");          // digit out of range for the base ends the field
    push_char(8'hFF);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        b = 2'(p);
        s = 2'(3 - p);
        write_reg(aifp_pkg::REG_SIGNED, 2'(p % 2));
      end else begin
        b = 2'($urandom_range(0, 3));
        s = 2'($urandom_range(0, 3));
        write_reg(aifp_pkg::REG_SIGNED, 2'($urandom_range(0, 3)));
      end
      write_reg(aifp_pkg::REG_BASE, b);
      write_reg(aifp_pkg::REG_SIZE, s);
      if (p % 3 == 0) write_reg(REG_SPARE, 2'($urandom_range(0, 3)));
      calm = ($urandom_range(0, 2) == 0);
      count = 0;
      while (count < PHASE_ITEMS) begin
        gen_field(b, n);
        count += n;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && fields_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[ascii_integer_field_parser.f]
+incdir+sv
sv/aifp_pkg.sv
sv/aifp_in_stage.sv
sv/aifp_core.sv
sv/ascii_integer_field_parser.sv
tb/tb_ascii_integer_field_parser.sv
